FILE: sv/ewrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewrs_pkg
// Constants, register codes, function tables and helpers for the Ewald
// real-space pair force pipeline.
// ----------------------------------------------------------------------------
package ewrs_pkg;

    localparam int FUNC_TABLE_ENTRIES = 1024;
    localparam int FINE_COUNT         = 2 * FUNC_TABLE_ENTRIES + 1;
    localparam int IDX_W              = $clog2(FUNC_TABLE_ENTRIES);
    localparam int ADDR_W             = IDX_W + 1;

    // Bit counts of the iterative units
    localparam int MOD_BITS = 34;
    localparam int RT_STEPS = 31;
    localparam int EM_BITS  = 47;
    localparam int FD_BITS  = 48;

    // Total register stages from the input edge up to and including the output register
    localparam int NSTG = (MOD_BITS + 1) + 3 + (RT_STEPS + 1) + 7 + (EM_BITS + 1) + 3
                        + (FD_BITS + 1) + 1;

    localparam int X_LIM_BITS = 35;   // kappa*r at or above 8.0 in Q.32

    localparam logic [30:0] ONE_Q30_V   = 31'h4000_0000;
    localparam logic [30:0] TWO_RPI_Q30 = 31'd1211587905;
    localparam logic [30:0] BOX_MAX     = 31'h7FFF_FFFF;
    localparam logic [47:0] MAX48       = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SAT_NEG_MAG = 48'h8000_0000_0000;

    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
    localparam logic [63:0] S2_Q60  = ((64'd1 << 62) / (64'(FUNC_TABLE_ENTRIES)
                                      * 64'(FUNC_TABLE_ENTRIES))) << 2;
    localparam logic [63:0] THREE_N = 64'(3 * FUNC_TABLE_ENTRIES);

    typedef enum logic [1:0] {
        CFG_CUTOFF_SQ = 2'd0,
        CFG_KAPPA     = 2'd1,
        CFG_BOX       = 2'd2,
        CFG_MODE      = 2'd3
    } t_cfg_idx;

    typedef logic [30:0] t_tab  [0:FUNC_TABLE_ENTRIES];
    typedef logic [30:0] t_fine [0:FINE_COUNT-1];

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // exp(-u) by a Taylor series, Q.60
    function automatic logic [63:0] exp_neg_small(input logic [63:0] u);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = ONE_Q60;
        term = ONE_Q60;
        for (int k = 1; k <= 20; k++) begin
            term = mul_q60(term, u) / 64'(k);
            if (k[0]) sum = sum - term;
            else      sum = sum + term;
        end
        return sum;
    endfunction

    // exp(-t^2) at half steps
    function automatic t_fine build_gauss();
        t_fine       g;
        logic [63:0] val;
        logic [63:0] m;
        logic [63:0] b;
        b   = exp_neg_small(S2_Q60 << 1);
        m   = exp_neg_small(S2_Q60);
        val = ONE_Q60;
        for (int i = 0; i < FINE_COUNT; i++) begin
            g[i] = 31'((val + (64'd1 << 29)) >> 30);
            val  = mul_q60(val, m);
            m    = mul_q60(m, b);
        end
        return g;
    endfunction

    function automatic t_tab build_gauss_even();
        t_fine g;
        t_tab  t;
        g = build_gauss();
        for (int i = 0; i <= FUNC_TABLE_ENTRIES; i++) t[i] = g[2 * i];
        return t;
    endfunction

    // erfc by Simpson integration from the top of the range downward
    function automatic t_tab build_erfc();
        t_fine       g;
        t_tab        t;
        logic [63:0] acc;
        logic [63:0] sum3;
        logic [63:0] e;
        g   = build_gauss();
        acc = 64'd0;
        t[FUNC_TABLE_ENTRIES] = 31'd0;
        for (int i = FUNC_TABLE_ENTRIES - 1; i >= 0; i--) begin
            sum3 = 64'(g[2 * i]) + 64'(g[2 * i + 1]) * 64'd4 + 64'(g[2 * i + 2]);
            acc  = acc + (sum3 * 64'(TWO_RPI_Q30)) / THREE_N;
            e    = acc >> 28;
            t[i] = (e > 64'(ONE_Q30_V)) ? ONE_Q30_V : 31'(e);
        end
        return t;
    endfunction

    localparam t_tab ERFC_TAB  = build_erfc();
    localparam t_tab GAUSS_TAB = build_gauss_even();

    // Apply sign to a magnitude and saturate to 48 bits
    function automatic logic [47:0] pack48(input logic neg, input logic sat,
                                           input logic [47:0] mag);
        logic [47:0] m;
        if (sat || mag[47]) m = neg ? SAT_NEG_MAG : MAX48;
        else                m = mag;
        return neg ? (48'd0 - m) : m;
    endfunction

endpackage

FILE: sv/ewald_real_space_pair_force.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is not stalled; the dividers,
// square root and box-modulo units resolve one bit per register stage, which
// sets the depth. A stall on the output freezes every stage; ready is high
// while output ready is high or the last stage holds no valid item.
// Reset clears the stage valid bits and loads the register defaults;
// the function tables are constant ROMs and need no clearing.
// ----------------------------------------------------------------------------
// ewald_real_space_pair_force
// Pipelined minimum-image Coulomb pair force and energy, bare or Ewald screened.
// ----------------------------------------------------------------------------
module ewald_real_space_pair_force
    import ewrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic signed [15:0] i_first_charge,
    input  logic signed [15:0] i_second_charge,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y,
    output logic signed [47:0] o_force_z,
    output logic signed [47:0] o_pair_energy,
    output logic               o_in_range
);

    typedef struct packed {
        logic [2:0][30:0] dabs;
        logic [2:0]       dneg;
        logic [30:0]      qmag;
        logic             qneg;
        logic [61:0]      dis2;
        logic             in_rng;
        logic             zero;
    } t_ctx;

    typedef struct packed {
        logic [2:0][33:0] num;
        logic [2:0]       neg;
        logic [2:0][31:0] rem;
        logic [30:0]      qmag;
        logic             qneg;
    } t_mod;

    typedef struct packed {
        logic [2:0][30:0] dabs;
        logic [2:0]       dneg;
        logic [30:0]      qmag;
        logic             qneg;
    } t_wrp;

    typedef struct packed {
        t_wrp             w;
        logic [2:0][61:0] sq;
    } t_sqr;

    typedef struct packed {
        t_ctx        c;
        logic [61:0] v;
        logic [61:0] res;
    } t_rt;

    typedef struct packed {
        t_ctx        c;
        logic [30:0] r;
        logic [46:0] x;
    } t_xs;

    typedef struct packed {
        t_ctx             c;
        logic [30:0]      r;
        logic             tab_en;
        logic             bare;
        logic [IDX_W-1:0] idx;
        logic [15:0]      fr;
    } t_lk;

    typedef struct packed {
        t_ctx        c;
        logic [30:0] r;
        logic        tab_en;
        logic        bare;
        logic [15:0] fr;
        logic [30:0] ea;
        logic [30:0] eb;
        logic [30:0] ga;
        logic [30:0] gb;
    } t_rd;

    typedef struct packed {
        t_ctx        c;
        logic [30:0] r;
        logic        tab_en;
        logic        bare;
        logic [47:0] pea;
        logic [47:0] peb;
        logic [47:0] pga;
        logic [47:0] pgb;
    } t_ip;

    typedef struct packed {
        t_ctx        c;
        logic [30:0] r;
        logic [30:0] erfc_v;
        logic [30:0] gauss_v;
    } t_fv;

    typedef struct packed {
        t_ctx        c;
        logic [30:0] r;
        logic [61:0] pe;
        logic [61:0] pg;
    } t_pp;

    typedef struct packed {
        t_ctx        c;
        logic [30:0] r;
        logic [46:0] en;
        logic [61:0] pt;
    } t_tt;

    typedef struct packed {
        t_ctx        c;
        logic [30:0] r;
        logic [46:0] num;
        logic [30:0] rem;
        logic [46:0] q;
        logic [31:0] tm;
    } t_ed;

    typedef struct packed {
        t_ctx        c;
        logic [47:0] smag;
        logic [47:0] energy;
    } t_sm;

    typedef struct packed {
        t_ctx             c;
        logic [47:0]      energy;
        logic [2:0][54:0] lo;
        logic [2:0][54:0] hi;
    } t_f1;

    typedef struct packed {
        t_ctx             c;
        logic [47:0]      energy;
        logic [2:0][78:0] pr;
    } t_f2;

    typedef struct packed {
        t_ctx             c;
        logic [47:0]      energy;
        logic [2:0][31:0] src;
        logic [2:0][61:0] rem;
        logic [2:0][47:0] q;
        logic [2:0]       sat;
    } t_fd;

    // Configuration
    logic [31:0] r_cut;
    logic [15:0] r_kappa;
    logic [30:0] r_box;
    logic        r_mode;
    logic [30:0] r_kc;

    // Pipeline
    logic [NSTG-1:0] r_vld;
    logic            w_adv;

    t_mod r_m  [0:MOD_BITS];
    t_wrp r_w;
    t_sqr r_q;
    t_ctx r_d;
    t_rt  r_s  [0:RT_STEPS];
    t_xs  r_x;
    t_lk  r_lk;
    t_rd  r_rd;
    t_ip  r_ip;
    t_fv  r_fv;
    t_pp  r_pp;
    t_tt  r_tt;
    t_ed  r_e  [0:EM_BITS];
    t_sm  r_sm;
    t_f1  r_f1;
    t_f2  r_f2;
    t_fd  r_fd [0:FD_BITS];

    logic [47:0] r_o_fx;
    logic [47:0] r_o_fy;
    logic [47:0] r_o_fz;
    logic [47:0] r_o_en;
    logic        r_o_rng;

    t_mod n_m0;
    t_wrp n_w;
    t_ctx n_s0;
    t_lk  n_lk;
    t_sm  n_sm;
    t_fd  n_fd0;
    logic [2:0][47:0] n_force;

    logic [31:0]       w_dv;
    logic [ADDR_W-1:0] w_a0;
    logic [ADDR_W-1:0] w_a1;
    logic [16:0]       w_fw;
    logic [63:0]       w_pos;

    // ------------------------------------------------------------------
    // Step functions of the bit-serial units
    // ------------------------------------------------------------------
    function automatic t_mod mod_step(input t_mod cur, input logic [31:0] dv);
        t_mod        nx;
        logic [32:0] t;
        nx = cur;
        for (int k = 0; k < 3; k++) begin
            t = {cur.rem[k], cur.num[k][33]};
            nx.num[k] = {cur.num[k][32:0], 1'b0};
            if (t >= {1'b0, dv}) nx.rem[k] = 32'(t - {1'b0, dv});
            else                 nx.rem[k] = t[31:0];
        end
        return nx;
    endfunction

    function automatic t_rt rt_step(input t_rt cur, input logic [61:0] bitv);
        t_rt         nx;
        logic [61:0] trial;
        nx    = cur;
        trial = cur.res + bitv;
        if (cur.v >= trial) begin
            nx.v   = cur.v - trial;
            nx.res = (cur.res >> 1) + bitv;
        end else begin
            nx.res = cur.res >> 1;
        end
        return nx;
    endfunction

    function automatic t_ed ed_step(input t_ed cur);
        t_ed         nx;
        logic [31:0] t;
        nx     = cur;
        t      = {cur.rem, cur.num[46]};
        nx.num = {cur.num[45:0], 1'b0};
        if (t >= {1'b0, cur.r}) begin
            nx.rem = 31'(t - {1'b0, cur.r});
            nx.q   = {cur.q[45:0], 1'b1};
        end else begin
            nx.rem = t[30:0];
            nx.q   = {cur.q[45:0], 1'b0};
        end
        return nx;
    endfunction

    function automatic t_fd fd_step(input t_fd cur);
        t_fd         nx;
        logic [62:0] t;
        nx = cur;
        for (int k = 0; k < 3; k++) begin
            t = {cur.rem[k], cur.src[k][31]};
            nx.src[k] = {cur.src[k][30:0], 1'b0};
            if (t >= {1'b0, cur.c.dis2}) begin
                nx.rem[k] = 62'(t - {1'b0, cur.c.dis2});
                nx.q[k]   = {cur.q[k][46:0], 1'b1};
            end else begin
                nx.rem[k] = t[61:0];
                nx.q[k]   = {cur.q[k][46:0], 1'b0};
            end
        end
        return nx;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut   <= 32'hFFFF_FFFF;
            r_kappa <= 16'd0;
            r_box   <= BOX_MAX;
            r_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CUTOFF_SQ: r_cut   <= i_cfg_data;
                CFG_KAPPA:     r_kappa <= i_cfg_data[15:0];
                // a zero box acts as the largest box
                CFG_BOX:       r_box   <= (i_cfg_data[30:0] == 31'd0) ? BOX_MAX
                                                                      : i_cfg_data[30:0];
                CFG_MODE:      r_mode  <= i_cfg_data[0];
                default:       r_mode  <= r_mode;
            endcase
        end
    end

    // kappa * 2/sqrt(pi), Q.30; follows the kappa register
    always_ff @(posedge i_clk) begin
        r_kc <= 31'((47'(r_kappa) * 47'(TWO_RPI_Q30)) >> 16);
    end

    // ------------------------------------------------------------------
    // Handshake: the whole pipeline advances together
    // ------------------------------------------------------------------
    assign w_adv       = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Entry: displacement, image numerator 2d+L, charge product
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [32:0] fd [0:2];
        logic signed [34:0] num;
        logic signed [31:0] qq;
        fd[0] = 33'(i_first_x) - 33'(i_second_x);
        fd[1] = 33'(i_first_y) - 33'(i_second_y);
        fd[2] = 33'(i_first_z) - 33'(i_second_z);
        n_m0  = '0;
        for (int k = 0; k < 3; k++) begin
            num = $signed({fd[k][32], fd[k], 1'b0}) + $signed({4'b0, r_box});
            n_m0.neg[k] = num[34];
            n_m0.num[k] = num[34] ? 34'(-num) : num[33:0];
        end
        qq = 32'(i_first_charge) * 32'(i_second_charge);
        n_m0.qneg = qq[31];
        n_m0.qmag = qq[31] ? 31'(-qq) : qq[30:0];
    end

    assign w_dv = {r_box, 1'b0};

    // Minimum image from the remainder of (2d+L) mod 2L: d' = (rem - L) / 2
    always_comb begin
        logic [31:0]        rf;
        logic signed [33:0] dv;
        logic signed [32:0] dw;
        n_w.qmag = r_m[MOD_BITS].qmag;
        n_w.qneg = r_m[MOD_BITS].qneg;
        for (int k = 0; k < 3; k++) begin
            rf = (r_m[MOD_BITS].neg[k] && (r_m[MOD_BITS].rem[k] != 32'd0))
               ? (w_dv - r_m[MOD_BITS].rem[k]) : r_m[MOD_BITS].rem[k];
            dv = $signed({2'b0, rf}) - $signed({3'b0, r_box});
            dw = dv[33:1];
            n_w.dneg[k] = dw[32];
            n_w.dabs[k] = dw[32] ? 31'(-dw) : dw[30:0];
        end
    end

    // Cutoff test and coincidence flag ahead of the square root
    always_comb begin
        n_s0        = r_d;
        n_s0.in_rng = r_d.dis2 < {14'd0, r_cut, 16'd0};
        n_s0.zero   = r_d.dis2 == 62'd0;
    end

    // Table position from kappa*r
    assign w_pos = (64'(r_x.x) * 64'(FUNC_TABLE_ENTRIES)) >> 19;

    always_comb begin
        n_lk.c      = r_x.c;
        n_lk.r      = r_x.r;
        n_lk.bare   = !r_mode;
        n_lk.tab_en = r_mode && (r_x.x[46:X_LIM_BITS] == '0);
        n_lk.idx    = w_pos[16 +: IDX_W];
        n_lk.fr     = w_pos[15:0];
    end

    assign w_a0 = ADDR_W'(r_lk.idx);
    assign w_a1 = ADDR_W'(r_lk.idx) + ADDR_W'(1);
    assign w_fw = 17'h1_0000 - {1'b0, r_rd.fr};

    // Energy magnitude and the screened force term
    always_comb begin
        t_ctx c;
        c          = r_e[EM_BITS].c;
        n_sm.c     = c;
        n_sm.smag  = 48'(r_e[EM_BITS].q) + 48'(r_e[EM_BITS].tm);
        if (!c.in_rng) begin
            n_sm.energy = 48'd0;
        end else if (c.zero) begin
            // coincident particles: saturate toward the sign of qq
            n_sm.energy = (c.qmag == 31'd0) ? 48'd0 : pack48(c.qneg, 1'b1, 48'd0);
        end else begin
            n_sm.energy = pack48(c.qneg, 1'b0, 48'(r_e[EM_BITS].q));
        end
    end

    // Start of the force division: flag quotients that cannot fit
    always_comb begin
        n_fd0.c      = r_f2.c;
        n_fd0.energy = r_f2.energy;
        for (int k = 0; k < 3; k++) begin
            n_fd0.sat[k] = {15'd0, r_f2.pr[k][78:32]} >= r_f2.c.dis2;
            n_fd0.rem[k] = 62'(r_f2.pr[k][78:32]);
            n_fd0.src[k] = r_f2.pr[k][31:0];
            n_fd0.q[k]   = 48'd0;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_fd[FD_BITS].c.in_rng && !r_fd[FD_BITS].c.zero) begin
                n_force[k] = pack48(r_fd[FD_BITS].c.qneg ^ r_fd[FD_BITS].c.dneg[k],
                                    r_fd[FD_BITS].sat[k], r_fd[FD_BITS].q[k]);
            end else begin
                n_force[k] = 48'd0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // box modulo, one bit a stage
            r_m[0] <= n_m0;
            for (int s = 0; s < MOD_BITS; s++) r_m[s+1] <= mod_step(r_m[s], w_dv);

            r_w <= n_w;

            r_q.w <= r_w;
            for (int k = 0; k < 3; k++) r_q.sq[k] <= 62'(r_w.dabs[k]) * 62'(r_w.dabs[k]);

            r_d.dabs   <= r_q.w.dabs;
            r_d.dneg   <= r_q.w.dneg;
            r_d.qmag   <= r_q.w.qmag;
            r_d.qneg   <= r_q.w.qneg;
            r_d.dis2   <= r_q.sq[0] + r_q.sq[1] + r_q.sq[2];
            r_d.in_rng <= 1'b0;
            r_d.zero   <= 1'b0;

            // integer square root, one result bit a stage
            r_s[0].c   <= n_s0;
            r_s[0].v   <= r_d.dis2;
            r_s[0].res <= 62'd0;
            for (int s = 0; s < RT_STEPS; s++) begin
                r_s[s+1] <= rt_step(r_s[s], 62'(64'd1 << (60 - 2 * s)));
            end

            r_x.c <= r_s[RT_STEPS].c;
            r_x.r <= r_s[RT_STEPS].res[30:0];
            r_x.x <= 47'(r_kappa) * 47'(r_s[RT_STEPS].res[30:0]);

            r_lk <= n_lk;

            // table ROMs, registered read at two neighbouring entries
            r_rd.c      <= r_lk.c;
            r_rd.r      <= r_lk.r;
            r_rd.tab_en <= r_lk.tab_en;
            r_rd.bare   <= r_lk.bare;
            r_rd.fr     <= r_lk.fr;
            r_rd.ea     <= ERFC_TAB[w_a0];
            r_rd.eb     <= ERFC_TAB[w_a1];
            r_rd.ga     <= GAUSS_TAB[w_a0];
            r_rd.gb     <= GAUSS_TAB[w_a1];

            r_ip.c      <= r_rd.c;
            r_ip.r      <= r_rd.r;
            r_ip.tab_en <= r_rd.tab_en;
            r_ip.bare   <= r_rd.bare;
            r_ip.pea    <= 48'(r_rd.ea) * 48'(w_fw);
            r_ip.peb    <= 48'(r_rd.eb) * 48'(r_rd.fr);
            r_ip.pga    <= 48'(r_rd.ga) * 48'(w_fw);
            r_ip.pgb    <= 48'(r_rd.gb) * 48'(r_rd.fr);

            r_fv.c <= r_ip.c;
            r_fv.r <= r_ip.r;
            if (r_ip.bare)        r_fv.erfc_v <= ONE_Q30_V;
            else if (r_ip.tab_en) r_fv.erfc_v <= 31'((r_ip.pea + r_ip.peb) >> 16);
            else                  r_fv.erfc_v <= 31'd0;
            r_fv.gauss_v <= r_ip.tab_en ? 31'((r_ip.pga + r_ip.pgb) >> 16) : 31'd0;

            r_pp.c  <= r_fv.c;
            r_pp.r  <= r_fv.r;
            r_pp.pe <= 62'(r_fv.c.qmag) * 62'(r_fv.erfc_v);
            r_pp.pg <= 62'(r_kc) * 62'(r_fv.gauss_v);

            r_tt.c  <= r_pp.c;
            r_tt.r  <= r_pp.r;
            r_tt.en <= r_pp.pe[60:14];
            r_tt.pt <= 62'(r_pp.c.qmag) * 62'(r_pp.pg[60:30]);

            // energy division by r, one quotient bit a stage
            r_e[0].c   <= r_tt.c;
            r_e[0].r   <= r_tt.r;
            r_e[0].num <= r_tt.en;
            r_e[0].rem <= 31'd0;
            r_e[0].q   <= 47'd0;
            r_e[0].tm  <= r_tt.pt[61:30];
            for (int s = 0; s < EM_BITS; s++) r_e[s+1] <= ed_step(r_e[s]);

            r_sm <= n_sm;

            // S * |d| in two partial products
            r_f1.c      <= r_sm.c;
            r_f1.energy <= r_sm.energy;
            for (int k = 0; k < 3; k++) begin
                r_f1.lo[k] <= 55'(r_sm.smag[23:0])  * 55'(r_sm.c.dabs[k]);
                r_f1.hi[k] <= 55'(r_sm.smag[47:24]) * 55'(r_sm.c.dabs[k]);
            end

            r_f2.c      <= r_f1.c;
            r_f2.energy <= r_f1.energy;
            for (int k = 0; k < 3; k++) begin
                r_f2.pr[k] <= 79'(r_f1.lo[k]) + {r_f1.hi[k], 24'd0};
            end

            // force division by dis2, one quotient bit a stage
            r_fd[0] <= n_fd0;
            for (int s = 0; s < FD_BITS; s++) r_fd[s+1] <= fd_step(r_fd[s]);

            r_o_fx  <= n_force[0];
            r_o_fy  <= n_force[1];
            r_o_fz  <= n_force[2];
            r_o_en  <= r_fd[FD_BITS].energy;
            r_o_rng <= r_fd[FD_BITS].c.in_rng;
        end
    end

    assign o_force_x     = r_o_fx;
    assign o_force_y     = r_o_fy;
    assign o_force_z     = r_o_fz;
    assign o_pair_energy = r_o_en;
    assign o_in_range    = r_o_rng;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("valid bits not cleared by reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted item missing from first stage");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_range) |->
            (o_force_x == 48'sd0) && (o_force_y == 48'sd0) && (o_force_z == 48'sd0)
            && (o_pair_energy == 48'sd0))
        else $error("non-zero result outside the cutoff");

endmodule
